// ===== rtl/core/look_at_view_matrix_core_defines.svh =====
// Assertion macros for the view matrix core.
// Both expect clk and arst_n in the scope of the use.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cons must hold in every cycle in which ante holds
`define LAVM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lavm: implication check failed");

// cond must hold in every cycle out of reset
`define LAVM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lavm: invariant check failed");

`else

`define LAVM_ASSERT_IMP(lbl, ante, cons)
`define LAVM_ASSERT_ALWAYS(lbl, cond)

`endif

`endif

// ===== rtl/core/lavm_pkg.sv =====
package lavm_pkg;

	// input coordinate width, signed Q.16
	localparam int COORD_WIDTH = 32;
	// eye minus target needs one more bit
	localparam int DIFF_W      = COORD_WIDTH + 1;
	// axis components, signed Q2.30
	localparam int AXIS_W      = 32;
	// translations, signed Q16.16
	localparam int SHIFT_W     = 32;
	localparam int UNIT_FRAC   = 30;
	localparam int EYE_FRAC    = 16;
	// exact cross product of two Q2.30 vectors
	localparam int CROSS_W     = 2 * AXIS_W - 1;
	// square root steps over a 64-bit radicand, two bits each
	localparam int ROOT_STEPS  = 32;

	// register counts of the units
	localparam int NORM_LAT    = 5 + ROOT_STEPS + 1 + UNIT_FRAC + 1;
	localparam int CROSS_LAT   = 2;
	localparam int DOT_LAT     = 4;
	localparam int LAT_TOTAL   = 1 + 3 * NORM_LAT + 2 * CROSS_LAT + DOT_LAT + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] eye_x;
		logic signed [COORD_WIDTH-1:0] eye_y;
		logic signed [COORD_WIDTH-1:0] eye_z;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
		logic signed [COORD_WIDTH-1:0] target_z;
		logic signed [COORD_WIDTH-1:0] up_x;
		logic signed [COORD_WIDTH-1:0] up_y;
		logic signed [COORD_WIDTH-1:0] up_z;
	} lavm_in_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0]  right_x;
		logic signed [AXIS_W-1:0]  right_y;
		logic signed [AXIS_W-1:0]  right_z;
		logic signed [AXIS_W-1:0]  upward_x;
		logic signed [AXIS_W-1:0]  upward_y;
		logic signed [AXIS_W-1:0]  upward_z;
		logic signed [AXIS_W-1:0]  back_x;
		logic signed [AXIS_W-1:0]  back_y;
		logic signed [AXIS_W-1:0]  back_z;
		logic signed [SHIFT_W-1:0] shift_x;
		logic signed [SHIFT_W-1:0] shift_y;
		logic signed [SHIFT_W-1:0] shift_z;
	} lavm_out_t;

endpackage

// ===== rtl/core/lavm_delay.sv =====
// Plain shift line that keeps data aligned with the valid chain
module lavm_delay #(
	parameter int W = 32,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_sk [N];

	always_ff @(posedge clk) begin
		line_sk[0] <= d;
		for (int i = 1; i < N; i++) begin
			line_sk[i] <= line_sk[i-1];
		end
	end

	assign q = line_sk[N-1];

endmodule

// ===== rtl/core/lavm_norm.sv =====
// Vector normalizer: prescale, sum of squares, pipelined integer root,
// then three pipelined restoring dividers that share the denominator.
// Stages: s1..s5 front, _sr root steps, s6 denominator, _sd divide steps, s7 out.
module lavm_norm #(
	parameter int VW = lavm_pkg::DIFF_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [VW-1:0]                vec [3],
	output logic                                out_vld,
	output logic signed [lavm_pkg::AXIS_W-1:0] unit [3]
);

	localparam int WW    = lavm_pkg::UNIT_FRAC;
	localparam int SW    = $clog2(VW);
	localparam int RW    = 64;
	localparam int NR    = lavm_pkg::ROOT_STEPS;
	localparam int ND    = WW;
	localparam int DENW  = 32;
	localparam int AW    = lavm_pkg::AXIS_W;

	typedef struct packed {
		logic [2:0][WW-1:0] w;
		logic [2:0]         neg;
	} side_t;

	// s1: magnitudes, signs, OR of magnitudes for the leading one
	logic [VW-1:0] mag_c [3];
	logic [2:0]    neg_c;
	logic [VW-1:0] orv_c;
	logic [VW-1:0] mag_s1 [3];
	logic [2:0]    neg_s1;
	logic [VW-1:0] orv_s1;
	logic          vld_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = vec[i][VW-1];
			mag_c[i] = neg_c[i] ? VW'(-vec[i]) : VW'(vec[i]);
		end
		orv_c = mag_c[0] | mag_c[1] | mag_c[2];
	end

	// s2: prescale amount so the largest magnitude drops below 2^30
	logic [SW-1:0] sh_c;
	logic [VW-1:0] mag_s2 [3];
	logic [2:0]    neg_s2;
	logic [SW-1:0] sh_s2;
	logic          vld_s2;

	always_comb begin
		sh_c = '0;
		for (int b = WW; b < VW; b++) begin
			if (orv_s1[b]) begin
				sh_c = SW'(b - WW + 1);
			end
		end
	end

	// s3: scaled magnitudes
	side_t side_c;
	side_t side_s3;
	logic  vld_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_c.w[i] = WW'(mag_s2[i] >> sh_s2);
		end
		side_c.neg = neg_s2;
	end

	// s4: squares, s5: sum of squares
	logic [2*WW-1:0] sq_s4 [3];
	side_t           side_s4;
	logic            vld_s4;
	logic [2*WW+1:0] sum_s5;
	side_t           side_s5;
	logic            vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag_c;
		neg_s1  <= neg_c;
		orv_s1  <= orv_c;
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		sh_s2   <= sh_c;
		side_s3 <= side_c;
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= side_s3.w[i] * side_s3.w[i];
		end
		side_s4 <= side_s3;
		sum_s5  <= {2'b00, sq_s4[0]} + {2'b00, sq_s4[1]} + {2'b00, sq_s4[2]};
		side_s5 <= side_s4;
	end

	// root: one result bit per step, floor of the square root
	logic [RW-1:0] rt_rem_sr  [NR];
	logic [RW-1:0] rt_root_sr [NR];
	side_t         rt_side_sr [NR];
	logic          rt_vld_sr  [NR];

	for (genvar j = 0; j < NR; j++) begin : g_root
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NR - 1 - j));
		logic [RW-1:0] rem_in, root_in, trial, rem_nx, root_nx;
		side_t         side_in;
		logic          vld_in;

		if (j == 0) begin : g_first
			assign rem_in  = RW'(sum_s5);
			assign root_in = '0;
			assign side_in = side_s5;
			assign vld_in  = vld_s5;
		end else begin : g_next
			assign rem_in  = rt_rem_sr[j-1];
			assign root_in = rt_root_sr[j-1];
			assign side_in = rt_side_sr[j-1];
			assign vld_in  = rt_vld_sr[j-1];
		end

		always_comb begin
			trial = root_in + BIT;
			if (rem_in >= trial) begin
				rem_nx  = rem_in - trial;
				root_nx = (root_in >> 1) + BIT;
			end else begin
				rem_nx  = rem_in;
				root_nx = root_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_sr[j] <= 1'b0;
			end else begin
				rt_vld_sr[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rt_rem_sr[j]  <= rem_nx;
			rt_root_sr[j] <= root_nx;
			rt_side_sr[j] <= side_in;
		end
	end

	// s6: denominator is root plus one, dividends are w * 2^30
	logic [DENW-1:0] den_s6;
	logic [2*WW-1:0] rem_s6 [3];
	logic [2:0]      neg_s6;
	logic            vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= rt_vld_sr[NR-1];
		end
	end

	always_ff @(posedge clk) begin
		den_s6 <= DENW'(rt_root_sr[NR-1]) + DENW'(1);
		for (int i = 0; i < 3; i++) begin
			rem_s6[i] <= {rt_side_sr[NR-1].w[i], {WW{1'b0}}};
		end
		neg_s6 <= rt_side_sr[NR-1].neg;
	end

	// divide: one quotient bit per step, three lanes
	logic [2*WW-1:0] dv_rem_sd [ND][3];
	logic [WW-1:0]   dv_q_sd   [ND][3];
	logic [DENW-1:0] dv_den_sd [ND];
	logic [2:0]      dv_neg_sd [ND];
	logic            dv_vld_sd [ND];

	for (genvar k = 0; k < ND; k++) begin : g_div
		localparam int B = WW - 1 - k;
		logic [2*WW-1:0] rem_in [3];
		logic [WW-1:0]   q_in   [3];
		logic [DENW-1:0] den_in;
		logic [2:0]      neg_in;
		logic            vld_in;
		logic [2*WW+1:0] trial;
		logic [2*WW-1:0] rem_nx [3];
		logic [WW-1:0]   q_nx   [3];

		if (k == 0) begin : g_first
			assign rem_in = rem_s6;
			assign q_in   = '{default: '0};
			assign den_in = den_s6;
			assign neg_in = neg_s6;
			assign vld_in = vld_s6;
		end else begin : g_next
			assign rem_in = dv_rem_sd[k-1];
			assign q_in   = dv_q_sd[k-1];
			assign den_in = dv_den_sd[k-1];
			assign neg_in = dv_neg_sd[k-1];
			assign vld_in = dv_vld_sd[k-1];
		end

		always_comb begin
			trial = (2*WW+2)'(den_in) << B;
			for (int i = 0; i < 3; i++) begin
				if ({2'b00, rem_in[i]} >= trial) begin
					rem_nx[i] = rem_in[i] - (2*WW)'(trial);
					q_nx[i]   = q_in[i] | (WW'(1) << B);
				end else begin
					rem_nx[i] = rem_in[i];
					q_nx[i]   = q_in[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sd[k] <= 1'b0;
			end else begin
				dv_vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_sd[k] <= rem_nx;
			dv_q_sd[k]   <= q_nx;
			dv_den_sd[k] <= den_in;
			dv_neg_sd[k] <= neg_in;
		end
	end

	// s7: restore signs
	logic signed [AW-1:0] unit_s7 [3];
	logic                 vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= dv_vld_sd[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			unit_s7[i] <= dv_neg_sd[ND-1][i] ? -AW'(dv_q_sd[ND-1][i])
				: AW'(dv_q_sd[ND-1][i]);
		end
	end

	assign out_vld = vld_s7;
	assign unit    = unit_s7;

endmodule

// ===== rtl/core/lavm_cross.sv =====
// Exact cross product a x b of two Q2.30 vectors, two register stages
module lavm_cross (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  logic signed [lavm_pkg::AXIS_W-1:0]  a [3],
	input  logic signed [lavm_pkg::AXIS_W-1:0]  b [3],
	output logic                                 out_vld,
	output logic signed [lavm_pkg::CROSS_W-1:0] c [3]
);

	localparam int PW = 2 * lavm_pkg::AXIS_W;
	localparam int CW = lavm_pkg::CROSS_W;

	// s1: the six partial products
	logic signed [PW-1:0] pp_s1 [6];
	logic                 vld_s1;
	// s2: differences
	logic signed [CW-1:0] c_s2 [3];
	logic                 vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1[0] <= a[1] * b[2];
		pp_s1[1] <= a[2] * b[1];
		pp_s1[2] <= a[2] * b[0];
		pp_s1[3] <= a[0] * b[2];
		pp_s1[4] <= a[0] * b[1];
		pp_s1[5] <= a[1] * b[0];
		c_s2[0]  <= CW'(pp_s1[0] - pp_s1[1]);
		c_s2[1]  <= CW'(pp_s1[2] - pp_s1[3]);
		c_s2[2]  <= CW'(pp_s1[4] - pp_s1[5]);
	end

	assign out_vld = vld_s2;
	assign c       = c_s2;

endmodule

// ===== rtl/core/lavm_dot.sv =====
// Translation lane: -floor(dot(axis, eye) / 2^30), saturated to 32 bits.
// The eye word is split at bit 16 so each product stays near 32x32.
module lavm_dot (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_vld,
	input  logic signed [lavm_pkg::AXIS_W-1:0]      axis [3],
	input  logic signed [lavm_pkg::COORD_WIDTH-1:0] eye  [3],
	output logic                                     out_vld,
	output logic signed [lavm_pkg::SHIFT_W-1:0]     shift
);

	localparam int CW  = lavm_pkg::COORD_WIDTH;
	localparam int AW  = lavm_pkg::AXIS_W;
	localparam int EF  = lavm_pkg::EYE_FRAC;
	localparam int OW  = lavm_pkg::SHIFT_W;
	localparam int EHW = CW - EF + 1;
	localparam int PHW = AW + EHW;
	localparam int PLW = AW + EF + 1;
	localparam int DW  = PHW + 2 + EF + 1;
	localparam int TW  = DW - lavm_pkg::UNIT_FRAC;

	// eye split into a signed high part and an unsigned low part
	logic signed [CW-1:0]  esh_c [3];
	logic signed [EHW-1:0] eh_c  [3];
	logic signed [EF:0]    el_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			esh_c[i] = eye[i] >>> EF;
			eh_c[i]  = esh_c[i][EHW-1:0];
			el_c[i]  = {1'b0, eye[i][EF-1:0]};
		end
	end

	// s1 products, s2 sums, s3 shifted dot, s4 negate and clamp
	logic signed [PHW-1:0] ph_s1 [3];
	logic signed [PLW-1:0] pl_s1 [3];
	logic signed [PHW+1:0] hi_s2;
	logic signed [PLW+1:0] lo_s2;
	logic signed [DW-1:0]  dot_c;
	logic signed [TW-1:0]  t_s3;
	logic signed [TW:0]    nt_c;
	logic                  ovf_c;
	logic signed [OW-1:0]  sat_c;
	logic signed [OW-1:0]  shift_s4;
	logic [3:0]            vld_q;

	always_comb begin
		dot_c = (DW'(hi_s2) <<< EF) + DW'(lo_s2);
		nt_c  = -((TW+1)'(t_s3));
		ovf_c = (nt_c[TW:OW-1] != '0) && (nt_c[TW:OW-1] != '1);
		if (ovf_c) begin
			sat_c = nt_c[TW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		end else begin
			sat_c = nt_c[OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ph_s1[i] <= axis[i] * eh_c[i];
			pl_s1[i] <= axis[i] * el_c[i];
		end
		hi_s2    <= (PHW+2)'(ph_s1[0]) + (PHW+2)'(ph_s1[1]) + (PHW+2)'(ph_s1[2]);
		lo_s2    <= (PLW+2)'(pl_s1[0]) + (PLW+2)'(pl_s1[1]) + (PLW+2)'(pl_s1[2]);
		t_s3     <= TW'(dot_c >>> lavm_pkg::UNIT_FRAC);
		shift_s4 <= sat_c;
	end

	assign out_vld = vld_q[3];
	assign shift   = shift_s4;

endmodule

// ===== rtl/core/look_at_view_matrix_core.sv =====
// View basis pipeline: takes one eye/target/up word in every clock (busy stays low) and
// returns its result word on result for one cycle with done high; the receiver cannot stall
// and none is needed. A word passes through the three vector normalizers in series (forward,
// right, recomputed up), each a 69-stage pipe made of a 32-step square root and a 30-step
// divider, plus the two cross products, the translation dot product and the input and output
// registers. Zero vectors give zero axes.
`include "look_at_view_matrix_core_defines.svh"

module look_at_view_matrix_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lavm_pkg::lavm_in_t   item,
	output logic                 done,
	output lavm_pkg::lavm_out_t  result
);

	localparam int CW    = lavm_pkg::COORD_WIDTH;
	localparam int DFW   = lavm_pkg::DIFF_W;
	localparam int AW    = lavm_pkg::AXIS_W;
	localparam int XW    = lavm_pkg::CROSS_W;
	localparam int STEP  = lavm_pkg::CROSS_LAT + lavm_pkg::NORM_LAT;
	localparam int EYE_D = 3 * lavm_pkg::NORM_LAT + 2 * lavm_pkg::CROSS_LAT;

	// fully pipelined, never holds off a word
	assign busy = 1'b0;

	// s1: forward difference, up vector and eye captured
	logic signed [DFW-1:0] diff_s1 [3];
	logic signed [DFW-1:0] up_s1   [3];
	logic [3*CW-1:0]       eye_s1;
	logic                  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1[0] <= DFW'(item.eye_x) - DFW'(item.target_x);
		diff_s1[1] <= DFW'(item.eye_y) - DFW'(item.target_y);
		diff_s1[2] <= DFW'(item.eye_z) - DFW'(item.target_z);
		up_s1[0]   <= DFW'(item.up_x);
		up_s1[1]   <= DFW'(item.up_y);
		up_s1[2]   <= DFW'(item.up_z);
		eye_s1     <= {item.eye_z, item.eye_y, item.eye_x};
	end

	// forward axis and normalized up in parallel
	logic signed [AW-1:0] az [3];
	logic signed [AW-1:0] ay0 [3];
	logic                 az_vld, ay0_vld;

	lavm_norm #(.VW(DFW)) u_norm_z (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .vec(diff_s1),
		.out_vld(az_vld), .unit(az)
	);

	lavm_norm #(.VW(DFW)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .vec(up_s1),
		.out_vld(ay0_vld), .unit(ay0)
	);

	// right axis = normalize(up x forward)
	logic signed [XW-1:0] c1 [3];
	logic                 c1_vld;
	logic signed [AW-1:0] ax [3];
	logic                 ax_vld;

	lavm_cross u_cross_x (
		.clk(clk), .arst_n(arst_n), .in_vld(az_vld), .a(ay0), .b(az),
		.out_vld(c1_vld), .c(c1)
	);

	lavm_norm #(.VW(XW)) u_norm_x (
		.clk(clk), .arst_n(arst_n), .in_vld(c1_vld), .vec(c1),
		.out_vld(ax_vld), .unit(ax)
	);

	// forward held until right is ready
	logic [3*AW-1:0]      az_d1_bus;
	logic signed [AW-1:0] az_d1 [3];

	lavm_delay #(.W(3*AW), .N(STEP)) u_dly_z1 (
		.clk(clk), .d({az[2], az[1], az[0]}), .q(az_d1_bus)
	);

	assign az_d1[0] = az_d1_bus[AW-1:0];
	assign az_d1[1] = az_d1_bus[2*AW-1:AW];
	assign az_d1[2] = az_d1_bus[3*AW-1:2*AW];

	// recomputed up = normalize(forward x right)
	logic signed [XW-1:0] c2 [3];
	logic                 c2_vld;
	logic signed [AW-1:0] ay [3];
	logic                 ay_vld;

	lavm_cross u_cross_y (
		.clk(clk), .arst_n(arst_n), .in_vld(ax_vld), .a(az_d1), .b(ax),
		.out_vld(c2_vld), .c(c2)
	);

	lavm_norm #(.VW(XW)) u_norm_y (
		.clk(clk), .arst_n(arst_n), .in_vld(c2_vld), .vec(c2),
		.out_vld(ay_vld), .unit(ay)
	);

	// align right, forward and eye with the recomputed up
	logic [3*AW-1:0]      ax_d_bus, az_d2_bus;
	logic [3*CW-1:0]      eye_d_bus;
	logic signed [AW-1:0] ax_d [3];
	logic signed [AW-1:0] az_d2 [3];
	logic signed [CW-1:0] eye_d [3];

	lavm_delay #(.W(3*AW), .N(STEP)) u_dly_x (
		.clk(clk), .d({ax[2], ax[1], ax[0]}), .q(ax_d_bus)
	);

	lavm_delay #(.W(3*AW), .N(STEP)) u_dly_z2 (
		.clk(clk), .d(az_d1_bus), .q(az_d2_bus)
	);

	lavm_delay #(.W(3*CW), .N(EYE_D)) u_dly_eye (
		.clk(clk), .d(eye_s1), .q(eye_d_bus)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax_d[i]  = ax_d_bus[i*AW +: AW];
			az_d2[i] = az_d2_bus[i*AW +: AW];
			eye_d[i] = eye_d_bus[i*CW +: CW];
		end
	end

	// translations
	logic signed [lavm_pkg::SHIFT_W-1:0] tx, ty, tz;
	logic                                tx_vld, ty_vld, tz_vld;

	lavm_dot u_dot_x (
		.clk(clk), .arst_n(arst_n), .in_vld(ay_vld), .axis(ax_d), .eye(eye_d),
		.out_vld(tx_vld), .shift(tx)
	);

	lavm_dot u_dot_y (
		.clk(clk), .arst_n(arst_n), .in_vld(ay_vld), .axis(ay), .eye(eye_d),
		.out_vld(ty_vld), .shift(ty)
	);

	lavm_dot u_dot_z (
		.clk(clk), .arst_n(arst_n), .in_vld(ay_vld), .axis(az_d2), .eye(eye_d),
		.out_vld(tz_vld), .shift(tz)
	);

	// axes wait for the dot lanes
	logic [9*AW-1:0] axes_bus;

	lavm_delay #(.W(9*AW), .N(lavm_pkg::DOT_LAT)) u_dly_axes (
		.clk(clk),
		.d({az_d2[2], az_d2[1], az_d2[0], ay[2], ay[1], ay[0],
			ax_d[2], ax_d[1], ax_d[0]}),
		.q(axes_bus)
	);

	// output word register
	lavm_pkg::lavm_out_t result_q;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tx_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.right_x  <= axes_bus[0*AW +: AW];
		result_q.right_y  <= axes_bus[1*AW +: AW];
		result_q.right_z  <= axes_bus[2*AW +: AW];
		result_q.upward_x <= axes_bus[3*AW +: AW];
		result_q.upward_y <= axes_bus[4*AW +: AW];
		result_q.upward_z <= axes_bus[5*AW +: AW];
		result_q.back_x   <= axes_bus[6*AW +: AW];
		result_q.back_y   <= axes_bus[7*AW +: AW];
		result_q.back_z   <= axes_bus[8*AW +: AW];
		result_q.shift_x  <= tx;
		result_q.shift_y  <= ty;
		result_q.shift_z  <= tz;
	end

	assign done   = done_q;
	assign result = result_q;

	// every result word traces back to an accepted word at the fixed latency
	`LAVM_ASSERT_IMP(a_done_latency, done, $past(start, lavm_pkg::LAT_TOTAL))
	// the two front normalizers run in lockstep
	`LAVM_ASSERT_ALWAYS(a_front_lockstep, az_vld == ay0_vld)
	// the three translation lanes stay aligned
	`LAVM_ASSERT_ALWAYS(a_dot_lockstep, (tx_vld == ty_vld) && (ty_vld == tz_vld))
	// a zero forward axis forces zero right and up axes
	`LAVM_ASSERT_IMP(a_zero_forward,
		done && (result.back_x == '0) && (result.back_y == '0) && (result.back_z == '0),
		(result.right_x == '0) && (result.right_y == '0) && (result.right_z == '0)
		&& (result.upward_x == '0) && (result.upward_y == '0) && (result.upward_z == '0))
	// the back x component never leaves the Q2.30 unit range
	`LAVM_ASSERT_IMP(a_unit_range, done,
		(result.back_x <= 32'sd1073741824) && (result.back_x >= -32'sd1073741824))

endmodule
